/* src/spq_pkg.sv */
// Shared types and constants for the sorted minimum priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // Queue geometry and field widths
    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_W       = 32;
    localparam int PAYLOAD_W   = 32;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Request transaction
    typedef struct packed {
        op_t                        operation;
        logic signed [KEY_W-1:0]    key;
        logic [PAYLOAD_W-1:0]       payload;
    } req_t;

    // Response transaction
    typedef struct packed {
        status_t                    status;
        logic signed [KEY_W-1:0]    out_key;
        logic [PAYLOAD_W-1:0]       out_payload;
        logic [COUNT_W-1:0]         occupancy;
    } rsp_t;

    // One stored entry of the chain
    typedef struct packed {
        logic                       vld;
        logic signed [KEY_W-1:0]    key;
        logic [PAYLOAD_W-1:0]       payload;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic                       push;
        logic                       pop;
        logic signed [KEY_W-1:0]    key;
        logic [PAYLOAD_W-1:0]       payload;
    } cell_cmd_t;

endpackage

/* src/spq_cell.sv */
// One cell of the sorted chain: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               left_less,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               less,
    output spq_pkg::entry_t    entry
);
    import spq_pkg::*;

    logic                    vld_reg;
    logic                    vld_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic [PAYLOAD_W-1:0]    payload_reg;
    logic [PAYLOAD_W-1:0]    payload_next;

    // Flag a held entry that stays ahead of the incoming key
    assign less = vld_reg && ($signed(key_reg) < $signed(cmd.key));

    assign entry.vld     = vld_reg;
    assign entry.key     = key_reg;
    assign entry.payload = payload_reg;

    // Choose keep, take new, take left or take right
    always_comb
    begin
        vld_next     = vld_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        if (cmd.push)
        begin
            if (!less)
            begin
                if (left_less)
                begin
                    vld_next     = 1'b1;
                    key_next     = cmd.key;
                    payload_next = cmd.payload;
                end
                else
                begin
                    vld_next     = left_entry.vld;
                    key_next     = left_entry.key;
                    payload_next = left_entry.payload;
                end
            end
        end
        else if (cmd.pop)
        begin
            vld_next     = right_entry.vld;
            key_next     = right_entry.key;
            payload_next = right_entry.payload;
        end
    end

    // Hold the valid flag under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Hold the entry data
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

endmodule

/* src/sorted_min_priority_queue.sv */
// Top level of the sorted minimum priority queue built from a chain of cells.
`timescale 1ns / 1ps

// Bounded min-priority queue of 16 entries, kept in ascending signed key order
// across a row of cells. Each request transaction is a push (key and payload) or
// a pop of the smallest entry, and gives exactly one response transaction with a
// status, the popped key and payload (zero unless a pop succeeded) and the count
// after the request. A new key goes ahead of held entries with an equal key.
// A push into a full queue is dropped with status 2, a pop from an empty queue
// returns status 1. Every cell compares its key against the incoming key in the
// same cycle and shifts left or right with its neighbors, so one request is taken
// each cycle and its response appears in the response register in the next cycle;
// the request side stalls only while that register holds a response that is
// itself stalled.
module sorted_min_priority_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic               accept;
    logic               is_empty;
    logic               is_full;
    cell_cmd_t          cmd;
    entry_t             cell_entry [QUEUE_DEPTH];
    logic               cell_less  [QUEUE_DEPTH];

    // Take a request unless a finished response is held back
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == COUNT_W'(QUEUE_DEPTH));

    // Broadcast the command, gated by the fill state
    always_comb
    begin
        cmd.push    = accept && (req.operation == OP_PUSH) && !is_full;
        cmd.pop     = accept && (req.operation == OP_POP) && !is_empty;
        cmd.key     = req.key;
        cmd.payload = req.payload;
    end

    // Build the chain of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   left_less;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_first
            assign left_less  = 1'b1;
            assign left_entry = '0;
        end
        else
        begin : g_inner
            assign left_less  = cell_less[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_entry = '0;
        end
        else
        begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_less   (left_less),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .less        (cell_less[i]),
            .entry       (cell_entry[i])
        );
    end

    // Advance the count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    // Form the response transaction
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (accept)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.status      = ST_DONE;
            rsp_next.out_key     = '0;
            rsp_next.out_payload = '0;
            rsp_next.occupancy   = count_next;
            if (req.operation == OP_POP)
            begin
                if (is_empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.out_key     = cell_entry[0].key;
                    rsp_next.out_payload = cell_entry[0].payload;
                end
            end
            else if (is_full)
            begin
                rsp_next.status = ST_FULL;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    // Hold the response payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* src/spq_checker.sv */
// Port-level checks for the sorted minimum priority queue and their binding.
`timescale 1ns / 1ps

module spq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input spq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    // A stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

    // A dropped push reports a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |->
            rsp.occupancy == COUNT_W'(QUEUE_DEPTH))
    else $error("full status without full occupancy");

    // A failed pop reports an empty queue and zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_EMPTY) |->
            (rsp.occupancy == '0) && (rsp.out_key == '0) && (rsp.out_payload == '0))
    else $error("empty status with data or entries");

    // Occupancy never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.occupancy <= COUNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

    // A taken request yields a response next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
    else $error("accepted request without response");

endmodule

bind sorted_min_priority_queue spq_checker u_spq_checker (.*);

/* dv/sorted_min_priority_queue_tb.sv */
// Self-checking testbench for the sorted minimum priority queue.
`timescale 1ns / 1ps

module sorted_min_priority_queue_tb;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int TAIL_ITEMS   = 200;

    // One pending request plus the idle gap that follows it
    typedef struct packed {
        req_t       txn;
        logic [4:0] gap_after;
        logic       calm;
    } stim_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    stim_t pending_q [$];
    rsp_t  expected_rsp_q [$];

    // Shadow copy of the queue contents, ascending by signed key
    logic signed [KEY_W-1:0] shadow_key [QUEUE_DEPTH];
    logic [PAYLOAD_W-1:0]    shadow_pay [QUEUE_DEPTH];
    int shadow_count = 0;

    int total_items  = 0;
    int sent_count   = 0;
    int error_count  = 0;
    int push_count   = 0;
    int pop_count    = 0;
    int full_count   = 0;
    int empty_count  = 0;
    int peak_count   = 0;

    int    gap_left   = 0;
    int    stall_left = 0;
    int    quiet_left = 0;
    int    stall_roll;
    logic  tail_phase = 1'b0;
    logic  txn_open;
    logic  next_stall;
    stim_t cur;
    rsp_t  want;

    sorted_min_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // Apply one request to the shadow queue and return the response it should give
    function automatic rsp_t predict_queue_response(req_t item);
        rsp_t                    res;
        int                      pos;
        logic signed [KEY_W-1:0] k;
        res = '0;
        k   = item.key;
        if (item.operation == OP_POP)
        begin
            pop_count++;
            if (shadow_count == 0)
            begin
                res.status = ST_EMPTY;
                empty_count++;
            end
            else
            begin
                res.status      = ST_DONE;
                res.out_key     = shadow_key[0];
                res.out_payload = shadow_pay[0];
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_key[i-1] = shadow_key[i];
                    shadow_pay[i-1] = shadow_pay[i];
                end
                shadow_count--;
            end
        end
        else
        begin
            push_count++;
            if (shadow_count >= QUEUE_DEPTH)
            begin
                res.status = ST_FULL;
                full_count++;
            end
            else
            begin
                // New key goes ahead of any held entry with an equal key
                pos = 0;
                while (pos < shadow_count && $signed(shadow_key[pos]) < k)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_key[i] = shadow_key[i-1];
                    shadow_pay[i] = shadow_pay[i-1];
                end
                shadow_key[pos] = k;
                shadow_pay[pos] = item.payload;
                shadow_count++;
                if (shadow_count > peak_count)
                    peak_count = shadow_count;
                res.status = ST_DONE;
            end
        end
        res.occupancy = COUNT_W'(shadow_count);
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] exp_val, logic [63:0] act_val);
        error_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
    endtask

    task automatic queue_item(op_t op, logic [31:0] key, logic [31:0] payload,
                              int gap, logic calm);
        stim_t s;
        s.txn.operation = op;
        s.txn.key       = key;
        s.txn.payload   = payload;
        s.gap_after     = gap[4:0];
        s.calm          = calm;
        pending_q.push_back(s);
        total_items++;
    endtask

    // Request driver: hold a transaction until accepted, then predict and advance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            gap_left  = 0;
        end
        else
        begin
            txn_open = req_valid;
            if (req_valid && !req_stall)
            begin
                expected_rsp_q.push_back(predict_queue_response(req));
                sent_count++;
                txn_open = 1'b0;
            end
            if (!txn_open)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    cur       = pending_q.pop_front();
                    req       <= cur.txn;
                    req_valid <= 1'b1;
                    gap_left  = cur.gap_after;
                    if (cur.calm)
                        tail_phase <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: check each accepted transaction and stall in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left = 0;
            quiet_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    report_mismatch("unexpected response", '0, 64'(rsp));
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (want.status !== rsp.status)
                        report_mismatch("status", 64'(want.status), 64'(rsp.status));
                    if (want.out_key !== rsp.out_key)
                        report_mismatch("out_key", 64'(want.out_key), 64'(rsp.out_key));
                    if (want.out_payload !== rsp.out_payload)
                        report_mismatch("out_payload", 64'(want.out_payload),
                                        64'(rsp.out_payload));
                    if (want.occupancy !== rsp.occupancy)
                        report_mismatch("occupancy", 64'(want.occupancy),
                                        64'(rsp.occupancy));
                end
            end

            // Pick the stall for the next cycle
            next_stall = 1'b0;
            if (tail_phase)
            begin
                stall_left = 0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                next_stall = 1'b1;
            end
            else if (quiet_left != 0)
            begin
                quiet_left--;
            end
            else
            begin
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 8)
                begin
                    stall_left = $urandom_range(1, 19) - 1;
                    next_stall = 1'b1;
                end
                else if (stall_roll < 10)
                begin
                    quiet_left = $urandom_range(50, 300);
                end
            end
            rsp_stall <= next_stall;
        end
    end

    // Build the stimulus, release reset, then wait for the queue to drain
    initial
    begin
        int                      n;
        int                      seg_len;
        int                      push_pct;
        int                      gap;
        logic                    idle_seg;
        logic                    calm;
        logic signed [KEY_W-1:0] k;
        op_t                     op;

        n = 0;

        // Pop from the empty queue with all field bits set
        queue_item(OP_POP, 32'hffff_ffff, 32'hffff_ffff, 0, 1'b0);
        // Fill to capacity: extreme keys, extreme payloads and equal-key runs
        queue_item(OP_PUSH, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        queue_item(OP_PUSH, 32'hffff_ffff, 32'hffff_ffff, 0, 1'b0);
        queue_item(OP_PUSH, 32'h7fff_ffff, 32'h0000_0001, 0, 1'b0);
        queue_item(OP_PUSH, 32'h8000_0000, 32'h0000_0002, 0, 1'b0);
        queue_item(OP_PUSH, 32'd5, 32'd10, 0, 1'b0);
        queue_item(OP_PUSH, 32'd5, 32'd11, 0, 1'b0);
        queue_item(OP_PUSH, 32'd5, 32'd12, 0, 1'b0);
        queue_item(OP_PUSH, -32'sd5, 32'h5555_5555, 0, 1'b0);
        queue_item(OP_PUSH, 32'd100, 32'haaaa_aaaa, 0, 1'b0);
        queue_item(OP_PUSH, 32'h8000_0000, 32'h0000_0003, 0, 1'b0);
        queue_item(OP_PUSH, 32'h7fff_ffff, 32'h0000_0004, 0, 1'b0);
        queue_item(OP_PUSH, 32'd42, 32'h8000_0000, 0, 1'b0);
        queue_item(OP_PUSH, -32'sd42, 32'h7fff_ffff, 0, 1'b0);
        queue_item(OP_PUSH, 32'd7, 32'd7, 0, 1'b0);
        queue_item(OP_PUSH, 32'd8, 32'd8, 0, 1'b0);
        queue_item(OP_PUSH, 32'd9, 32'd9, 0, 1'b0);
        // Push into the full queue, then take the smallest few
        queue_item(OP_PUSH, 32'd1, 32'h1234_5678, 0, 1'b0);
        repeat (4)
            queue_item(OP_POP, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);

        // Random segments that lean toward filling, draining or holding steady
        while (n < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0: push_pct = 25;
                1: push_pct = 50;
                default: push_pct = 75;
            endcase
            idle_seg = ($urandom_range(0, 3) != 0);
            for (int j = 0; j < seg_len && n < RANDOM_ITEMS; j++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: k = $urandom;
                    5, 6, 7: k = int'($urandom_range(0, 6)) - 3;
                    8:
                    begin
                        case ($urandom_range(0, 3))
                            0: k = 32'sh8000_0000;
                            1: k = 32'sh7fff_ffff;
                            2: k = '0;
                            default: k = -1;
                        endcase
                    end
                    default: k = {2'($urandom_range(0, 3)), 30'h0} |
                                 32'($urandom_range(0, 3));
                endcase
                op   = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                calm = (n >= RANDOM_ITEMS - TAIL_ITEMS);
                gap  = 0;
                if (!calm && idle_seg && $urandom_range(0, 5) == 0)
                    gap = $urandom_range(1, 19);
                queue_item(op, k, $urandom, gap, calm);
                n++;
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count != total_items)
            @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d transactions: %0d pushes (%0d dropped on full), %0d pops (%0d on empty).",
                 total_items, push_count, full_count, pop_count, empty_count);
        $display("Peak occupancy %0d of %0d, %0d mismatches.", peak_count, QUEUE_DEPTH, error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sorted_min_priority_queue.f */
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_min_priority_queue.sv
src/spq_checker.sv
dv/sorted_min_priority_queue_tb.sv
